@@ rtl/core/pcq_pkg.sv @@
// Shared types and codes for the priority command queue.
package pcq_pkg;

  localparam logic [2:0] CMD_INIT     = 3'd0;
  localparam logic [2:0] CMD_ENQUEUE  = 3'd1;
  localparam logic [2:0] CMD_CANCEL   = 3'd2;
  localparam logic [2:0] CMD_DISPATCH = 3'd3;
  localparam logic [2:0] CMD_MARK_ALL = 3'd4;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_NOT_RUNNING = 3'd1;
  localparam logic [2:0] ST_QUEUED      = 3'd2;
  localparam logic [2:0] ST_NONE        = 3'd3;
  localparam logic [2:0] ST_BAD_PRIO    = 3'd4;

  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_CANCEL   = 2'd2;

  localparam logic [0:0] CFG_RUNNING  = 1'b0;
  localparam logic [0:0] CFG_NUM_PRIO = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_OUT
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
  } sts_t;

  typedef struct packed {
    logic [2:0] status;
    logic [1:0] result_kind;
    logic [4:0] out_command;
    logic [2:0] out_priority;
    logic       cancel_mark;
  } result_t;

endpackage

@@ rtl/core/pcq_ctrl.sv @@
// Controller state machine sequencing load, execute and output of one beat.
module pcq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_fire,
  input  logic          out_fire,
  input  pcq_pkg::sts_t sts,
  output pcq_pkg::ctl_t ctl,
  output logic          in_ready,
  output logic          out_valid
);

  pcq_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pcq_pkg::S_IDLE: if (in_fire) state_nxt = pcq_pkg::S_EXEC;
      pcq_pkg::S_EXEC: if (!sts.busy) state_nxt = pcq_pkg::S_OUT;
      pcq_pkg::S_OUT:  if (out_fire) state_nxt = pcq_pkg::S_IDLE;
      default:         state_nxt = pcq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl.load  = 1'b0;
    ctl.exec  = 1'b0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      pcq_pkg::S_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_fire;
      end
      pcq_pkg::S_EXEC: ctl.exec = 1'b1;
      pcq_pkg::S_OUT:  out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

@@ rtl/core/pcq_dp.sv @@
// Datapath: slot flags, linked lists and the result register.
module pcq_dp #(
  parameter int MAX_COMMANDS   = 32,
  parameter int MAX_PRIORITIES = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pcq_pkg::ctl_t     ctl,
  output pcq_pkg::sts_t     sts,
  input  logic [2:0]        cmd,
  input  logic [4:0]        command_id,
  input  logic [2:0]        priority_req,
  input  logic              running,
  input  logic [3:0]        level_count,
  output pcq_pkg::result_t  res
);

  localparam int IW = (MAX_COMMANDS > 1) ? $clog2(MAX_COMMANDS) : 1;
  localparam int LW = (MAX_PRIORITIES > 1) ? $clog2(MAX_PRIORITIES) : 1;
  localparam int NW = $clog2(MAX_PRIORITIES + 1);

  logic [MAX_COMMANDS-1:0]   queued_r, cancel_r;
  logic [2:0]                sprio_r [MAX_COMMANDS];
  logic [IW-1:0]             next_r  [MAX_COMMANDS];
  logic [IW-1:0]             prev_r  [MAX_COMMANDS];
  logic [IW-1:0]             head_r  [MAX_PRIORITIES];
  logic [IW-1:0]             tail_r  [MAX_PRIORITIES];
  logic [MAX_PRIORITIES-1:0] nonempty_r;

  logic [2:0] cmd_r, prio_r;
  logic [4:0] id_r;
  logic [NW-1:0] np_r;
  logic run_r;
  pcq_pkg::result_t res_r, res_nxt;

  // Level count saturated to 1..MAX_PRIORITIES.
  logic [NW-1:0] np_sat;
  always_comb begin
    if (level_count == 4'd0) np_sat = NW'(1);
    else if ({1'b0, level_count} > 5'(MAX_PRIORITIES)) np_sat = NW'(MAX_PRIORITIES);
    else np_sat = NW'(level_count);
  end

  // Highest eligible nonempty level.
  logic          found;
  logic [LW-1:0] top_lvl;
  always_comb begin
    found   = 1'b0;
    top_lvl = '0;
    for (int l = 0; l < MAX_PRIORITIES; l++) begin
      if (nonempty_r[l] && (NW'(l) < np_r)) begin
        found   = 1'b1;
        top_lvl = LW'(l);
      end
    end
  end

  logic          id_ok;
  logic [IW-1:0] idx;
  assign id_ok = {27'd0, id_r} < 32'(MAX_COMMANDS);
  assign idx   = IW'(id_r);
  assign sts.busy = 1'b0;

  // Target slot for unlink: the cancelled slot or the dispatched head.
  logic [IW-1:0] u_id, u_p, u_n;
  logic [LW-1:0] u_lvl;
  logic          u_head, u_tail;
  always_comb begin
    if (cmd_r == pcq_pkg::CMD_DISPATCH) begin
      u_id  = head_r[top_lvl];
      u_lvl = top_lvl;
    end else begin
      u_id  = idx;
      u_lvl = LW'(sprio_r[idx]);
    end
    u_p    = prev_r[u_id];
    u_n    = next_r[u_id];
    u_head = head_r[u_lvl] == u_id;
    u_tail = tail_r[u_lvl] == u_id;
  end

  // An enqueue that passes every check, and a cancel or dispatch that has a slot.
  logic enq_ok, unl_ok;
  assign enq_ok = id_ok && run_r && !queued_r[idx] && (32'(prio_r) < 32'(np_r));
  assign unl_ok = (cmd_r == pcq_pkg::CMD_CANCEL) ? (id_ok && queued_r[idx]) : found;

  always_comb begin
    res_nxt = '{pcq_pkg::ST_OK, pcq_pkg::KIND_NONE, 5'd0, 3'd0, 1'b0};
    case (cmd_r)
      pcq_pkg::CMD_INIT: begin
        if (!id_ok) res_nxt.status = pcq_pkg::ST_NONE;
        else if (queued_r[idx]) res_nxt.status = pcq_pkg::ST_QUEUED;
      end
      pcq_pkg::CMD_ENQUEUE: begin
        if (!id_ok) res_nxt.status = pcq_pkg::ST_NONE;
        else if (!run_r) res_nxt.status = pcq_pkg::ST_NOT_RUNNING;
        else if (queued_r[idx]) res_nxt.status = pcq_pkg::ST_QUEUED;
        else if (!enq_ok) res_nxt.status = pcq_pkg::ST_BAD_PRIO;
      end
      pcq_pkg::CMD_CANCEL: begin
        if (!unl_ok) res_nxt.status = pcq_pkg::ST_NONE;
        else begin
          res_nxt.result_kind  = pcq_pkg::KIND_CANCEL;
          res_nxt.out_command  = 5'(u_id);
          res_nxt.out_priority = sprio_r[u_id];
        end
      end
      pcq_pkg::CMD_DISPATCH: begin
        if (!unl_ok) res_nxt.status = pcq_pkg::ST_NONE;
        else begin
          res_nxt.result_kind  = pcq_pkg::KIND_DISPATCH;
          res_nxt.out_command  = 5'(u_id);
          res_nxt.out_priority = 3'(top_lvl);
          res_nxt.cancel_mark  = cancel_r[u_id];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= cmd;
      id_r   <= command_id;
      prio_r <= priority_req;
      np_r   <= np_sat;
      run_r  <= running;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      queued_r   <= '0;
      cancel_r   <= '0;
      nonempty_r <= '0;
    end else if (ctl.exec) begin
      res_r <= res_nxt;
      case (cmd_r)
        pcq_pkg::CMD_INIT: begin
          if (id_ok && !queued_r[idx]) cancel_r[idx] <= 1'b0;
        end
        pcq_pkg::CMD_ENQUEUE: begin
          if (enq_ok) begin
            if (nonempty_r[LW'(prio_r)]) begin
              next_r[tail_r[LW'(prio_r)]] <= idx;
              prev_r[idx] <= tail_r[LW'(prio_r)];
            end else begin
              head_r[LW'(prio_r)] <= idx;
              nonempty_r[LW'(prio_r)] <= 1'b1;
            end
            tail_r[LW'(prio_r)] <= idx;
            queued_r[idx] <= 1'b1;
            sprio_r[idx] <= prio_r;
          end
        end
        pcq_pkg::CMD_CANCEL, pcq_pkg::CMD_DISPATCH: begin
          if (unl_ok) begin
            if (u_head && u_tail) nonempty_r[u_lvl] <= 1'b0;
            else if (u_head) head_r[u_lvl] <= u_n;
            else if (u_tail) tail_r[u_lvl] <= u_p;
            else begin
              next_r[u_p] <= u_n;
              prev_r[u_n] <= u_p;
            end
            queued_r[u_id] <= 1'b0;
          end
        end
        pcq_pkg::CMD_MARK_ALL: begin
          for (int i = 0; i < MAX_COMMANDS; i++) begin
            if (queued_r[i] && (32'(sprio_r[i]) < 32'(np_r))) cancel_r[i] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign res = res_r;

endmodule

@@ rtl/core/priority_command_queue_with_cancel.sv @@
// Top level of the strict-priority command queue with cancel.
// Each input beat carries one command: init, enqueue, cancel, dispatch or
// mark-all. The block keeps one FIFO of slot numbers per priority level as
// doubly linked lists and answers every command with exactly one result beat.
// Configuration writes (index 0 running, index 1 level count) go through the
// cfg channel, which is always ready; write it only while the block is idle.
// An input beat is taken in the idle state and executed in the next cycle;
// its result beat is valid from the following cycle. The next beat is
// accepted in the cycle after the result has been taken, so the block takes
// no new command until the previous result has left. If the receiver stalls,
// the result beat holds on out_tdata and in_tready stays low. Synchronous
// active-low reset empties every list, clears all queued and cancel marks,
// stops the block and sets one level.
module priority_command_queue_with_cancel #(
  parameter int MAX_COMMANDS   = 32,
  parameter int MAX_PRIORITIES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // cmd[2:0], command_id[7:3], priority_req[10:8]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status[2:0], result_kind[4:3], out_command[9:5],
                                  // out_priority[12:10], cancel_mark[13]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  logic running_r;
  logic [3:0] num_prio_r;
  pcq_pkg::ctl_t ctl;
  pcq_pkg::sts_t sts;
  pcq_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      num_prio_r <= 4'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        pcq_pkg::CFG_RUNNING:  running_r  <= cfg_data[0];
        pcq_pkg::CFG_NUM_PRIO: num_prio_r <= cfg_data;
        default: ;
      endcase
    end
  end

  pcq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_tvalid && in_tready),
    .out_fire  (out_tvalid && out_tready),
    .sts       (sts),
    .ctl       (ctl),
    .in_ready  (in_tready),
    .out_valid (out_tvalid)
  );

  pcq_dp #(
    .MAX_COMMANDS   (MAX_COMMANDS),
    .MAX_PRIORITIES (MAX_PRIORITIES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .cmd            (in_tdata[2:0]),
    .command_id     (in_tdata[7:3]),
    .priority_req   (in_tdata[10:8]),
    .running        (running_r),
    .level_count    (num_prio_r),
    .res            (res)
  );

  assign out_tdata = {2'b00, res.cancel_mark, res.out_priority, res.out_command,
                      res.result_kind, res.status};

endmodule

@@ dv/pcq_checker.sv @@
// Checker that predicts and compares the results of the priority command queue.
module pcq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  logic       q_flag [32];
  logic       c_flag [32];
  logic [2:0] s_prio [32];
  logic [4:0] nxt [32];
  logic [4:0] prv [32];
  logic [4:0] head [8];
  logic [4:0] tail [8];
  logic       nonempty [8];
  logic       run_en;
  logic [3:0] level_reg;

  pcq_pkg::result_t expected_results [$];

  function automatic int levels_in_use();
    if (level_reg < 1) return 1;
    if (level_reg > 8) return 8;
    return int'(level_reg);
  endfunction

  task automatic unlink(input logic [4:0] id);
    logic [2:0] lv;
    lv = s_prio[id];
    if (head[lv] == id && tail[lv] == id) nonempty[lv] = 1'b0;
    else if (head[lv] == id) head[lv] = nxt[id];
    else if (tail[lv] == id) tail[lv] = prv[id];
    else begin
      nxt[prv[id]] = nxt[id];
      prv[nxt[id]] = prv[id];
    end
    q_flag[id] = 1'b0;
  endtask

  task automatic predict_command(input logic [15:0] beat);
    logic [2:0] cmd;
    logic [4:0] id;
    logic [2:0] pr;
    int np;
    pcq_pkg::result_t r;
    cmd = beat[2:0];
    id = beat[7:3];
    pr = beat[10:8];
    np = levels_in_use();
    r = '0;
    case (cmd)
      pcq_pkg::CMD_INIT: begin
        if (q_flag[id]) r.status = pcq_pkg::ST_QUEUED;
        else c_flag[id] = 1'b0;
      end
      pcq_pkg::CMD_ENQUEUE: begin
        if (!run_en) r.status = pcq_pkg::ST_NOT_RUNNING;
        else if (q_flag[id]) r.status = pcq_pkg::ST_QUEUED;
        else if (int'(pr) >= np) r.status = pcq_pkg::ST_BAD_PRIO;
        else begin
          if (nonempty[pr]) begin
            nxt[tail[pr]] = id;
            prv[id] = tail[pr];
          end else begin
            head[pr] = id;
            nonempty[pr] = 1'b1;
          end
          tail[pr] = id;
          q_flag[id] = 1'b1;
          s_prio[id] = pr;
        end
      end
      pcq_pkg::CMD_CANCEL: begin
        if (!q_flag[id]) r.status = pcq_pkg::ST_NONE;
        else begin
          r.out_priority = s_prio[id];
          unlink(id);
          r.result_kind = pcq_pkg::KIND_CANCEL;
          r.out_command = id;
        end
      end
      pcq_pkg::CMD_DISPATCH: begin
        r.status = pcq_pkg::ST_NONE;
        for (int lv = np - 1; lv >= 0; lv--) begin
          if (nonempty[lv]) begin
            r.status = pcq_pkg::ST_OK;
            r.result_kind = pcq_pkg::KIND_DISPATCH;
            r.out_command = head[lv];
            r.out_priority = 3'(lv);
            r.cancel_mark = c_flag[head[lv]];
            unlink(head[lv]);
            break;
          end
        end
      end
      pcq_pkg::CMD_MARK_ALL: begin
        for (int i = 0; i < 32; i++)
          if (q_flag[i] && int'(s_prio[i]) < np) c_flag[i] = 1'b1;
      end
      default: ;
    endcase
    expected_results.push_back(r);
  endtask

  always @(posedge clk) begin
    pcq_pkg::result_t got;
    pcq_pkg::result_t want;
    if (!rst_n) begin
      for (int i = 0; i < 32; i++) begin
        q_flag[i] = 0; c_flag[i] = 0; s_prio[i] = 0; nxt[i] = 0; prv[i] = 0;
      end
      for (int i = 0; i < 8; i++) begin
        head[i] = 0; tail[i] = 0; nonempty[i] = 0;
      end
      run_en = 0;
      level_reg = 4'd1;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        // Fields sit from the lowest bit up on the bus.
        got.status       = out_tdata[2:0];
        got.result_kind  = out_tdata[4:3];
        got.out_command  = out_tdata[9:5];
        got.out_priority = out_tdata[12:10];
        got.cancel_mark  = out_tdata[13];
        result_count++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result beat %h", out_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got !== want || out_tdata[15:14] !== 2'b00) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: expected st=%0d kind=%0d cmd=%0d prio=%0d mark=%0d",
                       want.status, want.result_kind, want.out_command,
                       want.out_priority, want.cancel_mark);
              $display("          got st=%0d kind=%0d cmd=%0d prio=%0d mark=%0d (%h)",
                       got.status, got.result_kind, got.out_command,
                       got.out_priority, got.cancel_mark, out_tdata);
            end
          end
        end
      end
      if (in_tvalid && in_tready) predict_command(in_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == pcq_pkg::CFG_RUNNING) run_en = cfg_data[0];
        else level_reg = cfg_data;
      end
    end
    pending = expected_results.size();
  end

endmodule

@@ dv/priority_command_queue_with_cancel_tb.sv @@
// Top of the testbench for the priority command queue: stimulus and verdict.
module priority_command_queue_with_cancel_tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  int          fail_count;
  int          pending;
  int          result_count;
  int          idle_cycles = 0;
  int          beats_sent = 0;
  int          cfg_writes = 0;

  // Watchdog limit on consecutive cycles with no beat on any channel. The
  // longest legal gap is a sender or receiver stall from gap_length plus
  // the drain wait, so this leaves a wide margin.
  localparam int IDLE_LIMIT = 2000;

  always #4 clk = ~clk;

  priority_command_queue_with_cancel uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pcq_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .result_count(result_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  // Receiver side: random backpressure with stretches of none at all.
  initial begin
    int stall;
    int calm;
    calm = 0;
    forever begin
      @(negedge clk);
      if (calm > 0) begin
        calm--;
        out_tready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        calm = $urandom_range(20, 80);
        out_tready <= 1'b1;
      end else begin
        stall = gap_length();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall - 1) @(negedge clk);
          @(negedge clk);
        end
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", IDLE_LIMIT);
      $display("priority_command_queue_with_cancel_tb: done, errors");
      $finish;
    end
  end

  // One input beat; the gap before it is random unless zero is forced. The
  // wait before the beat is raised costs nothing, since in_tready stays low
  // after each beat until its result has been taken.
  task automatic send_command(input logic [2:0] cmd, input logic [4:0] id,
                              input logic [2:0] pr, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_length();
    @(negedge clk);
    repeat (gap) @(negedge clk);
    in_tdata <= {5'b0, pr, id, cmd};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Waits until every result has arrived and the block has settled.
  task automatic drain();
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register writes are done only while the block is idle.
  task automatic write_reg(input logic [0:0] idx, input logic [3:0] value);
    drain();
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random command mix weighted so the lists fill and empty often.
  task automatic random_command(input int np_hint);
    int pick;
    logic [2:0] cmd;
    logic [2:0] pr;
    pick = $urandom_range(0, 99);
    if (pick < 40) cmd = pcq_pkg::CMD_ENQUEUE;
    else if (pick < 58) cmd = pcq_pkg::CMD_DISPATCH;
    else if (pick < 78) cmd = pcq_pkg::CMD_CANCEL;
    else if (pick < 88) cmd = pcq_pkg::CMD_INIT;
    else if (pick < 95) cmd = pcq_pkg::CMD_MARK_ALL;
    else cmd = 3'($urandom_range(5, 7));
    if ($urandom_range(0, 9) == 0) pr = 3'($urandom_range(0, 7));
    else pr = 3'($urandom_range(0, np_hint - 1));
    send_command(cmd, 5'($urandom_range(0, 31)), pr, 1'b0);
  endtask

  initial begin
    int np;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Enqueue before start is refused.
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd0, 3'd0, 1'b0);
    send_command(pcq_pkg::CMD_DISPATCH, 5'd0, 3'd0, 1'b0);
    write_reg(pcq_pkg::CFG_RUNNING, 4'd1);
    write_reg(pcq_pkg::CFG_NUM_PRIO, 4'd8);
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd0, 3'd0, 1'b1);
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd31, 3'd7, 1'b1);
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd5, 3'd7, 1'b1);
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd9, 3'd7, 1'b1);
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd31, 3'd3, 1'b0);  // already queued
    send_command(pcq_pkg::CMD_INIT, 5'd31, 3'd0, 1'b0);     // init of a queued slot
    send_command(pcq_pkg::CMD_CANCEL, 5'd5, 3'd0, 1'b0);    // middle of a list
    send_command(pcq_pkg::CMD_CANCEL, 5'd5, 3'd0, 1'b0);    // slot no longer queued
    send_command(pcq_pkg::CMD_MARK_ALL, 5'd0, 3'd0, 1'b0);
    send_command(pcq_pkg::CMD_DISPATCH, 5'd0, 3'd0, 1'b0);  // marked head
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd31, 3'd7, 1'b0);  // mark survives re-enqueue
    send_command(pcq_pkg::CMD_DISPATCH, 5'd0, 3'd0, 1'b0);
    send_command(pcq_pkg::CMD_DISPATCH, 5'd0, 3'd0, 1'b0);
    send_command(pcq_pkg::CMD_INIT, 5'd31, 3'd0, 1'b0);
    send_command(3'd7, 5'd31, 3'd7, 1'b0);                  // unused command code
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd12, 3'd6, 1'b0);
    write_reg(pcq_pkg::CFG_NUM_PRIO, 4'd2);                 // shrink below a queued level
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd13, 3'd2, 1'b0);  // bad priority
    send_command(pcq_pkg::CMD_MARK_ALL, 5'd0, 3'd0, 1'b0);
    send_command(pcq_pkg::CMD_DISPATCH, 5'd0, 3'd0, 1'b0);  // level 6 is hidden
    send_command(pcq_pkg::CMD_CANCEL, 5'd12, 3'd0, 1'b0);   // hidden slot can be cancelled
    write_reg(pcq_pkg::CFG_NUM_PRIO, 4'd0);                 // saturates to one level
    send_command(pcq_pkg::CMD_ENQUEUE, 5'd3, 3'd1, 1'b0);
    send_command(pcq_pkg::CMD_DISPATCH, 5'd0, 3'd0, 1'b0);

    // Random part in phases with different settings, extremes included.
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: np = 8;
        1: np = 1;
        2: np = 15;
        3: np = 3;
        default: np = $urandom_range(0, 15);
      endcase
      write_reg(pcq_pkg::CFG_NUM_PRIO, 4'(np));
      write_reg(pcq_pkg::CFG_RUNNING, (phase == 5) ? 4'd0 : 4'd1);
      if (np < 1) np = 1;
      if (np > 8) np = 8;
      for (int k = 0; k < 82; k++) begin
        random_command(np);
        // The sender holds off now and then until all results are back.
        if (k == 40) drain();
      end
    end
    drain();
    repeat (20) @(negedge clk);
    $display("sent %0d command beats, checked %0d results, %0d register writes",
             beats_sent, result_count, cfg_writes);
    if (fail_count == 0 && pending == 0)
      $display("priority_command_queue_with_cancel_tb: done, clean");
    else
      $display("priority_command_queue_with_cancel_tb: done, errors");
    $finish;
  end

endmodule
